/* sv/popcount_adder_witness_defines.svh */
// Assertion macros for the popcount adder witness block.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef POPCOUNT_ADDER_WITNESS_DEFINES_SVH
`define POPCOUNT_ADDER_WITNESS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PCAW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PCAW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pcaw_pkg.sv */
// Shared constants and controller/datapath interface types for the popcount witness.
// No dependencies.
package pcaw_pkg;

    localparam int MAX_BITS    = 128;
    localparam int IN_BYTES    = (MAX_BITS + 7) / 8;
    localparam int STORE_BYTES = (3 * MAX_BITS + 7) / 8;

    localparam int LP_W      = $clog2(IN_BYTES + 1);
    localparam int IB_IDX_W  = $clog2(IN_BYTES);
    localparam int POS_W     = $clog2(STORE_BYTES * 8 + 1);
    localparam int MEM_AW    = $clog2(STORE_BYTES);
    localparam int NB_W      = $clog2(STORE_BYTES + 1);
    localparam int CNT_W     = $clog2(MAX_BITS + 1);
    localparam int LV_IDX_W  = $clog2(MAX_BITS);

    localparam int BC_W      = 8;
    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 6;
    localparam int WEIGHT_W  = 8;

    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_BIT_COUNT   = REG_IDX_W'(0);
    localparam logic [BC_W-1:0]      BIT_COUNT_RESET = BC_W'(128);

    typedef struct packed {
        logic load;
        logic capture;
        logic emit_in;
        logic walk_init;
        logic walk;
        logic next_level;
        logic emit_car;
        logic flush;
        logic out_start;
        logic out_load;
        logic out_adv;
    } pcaw_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic len_one;
        logic out_last;
    } pcaw_stat_t;

endpackage

/* sv/pcaw_cfg.sv */
// Configuration register file: APB-style write/read of bit_count.
// Depends on pcaw_pkg.
module pcaw_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcaw_pkg::ADDR_W-1:0]  paddr,
    input  logic [pcaw_pkg::DATA_W-1:0]  pwdata,
    output logic [pcaw_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [pcaw_pkg::BC_W-1:0]    bit_count
);
    import pcaw_pkg::*;

    logic [BC_W-1:0]      bit_count_reg;
    logic [BC_W-1:0]      bit_count_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        bit_count_next = bit_count_reg;
        if (wr_en && (reg_idx == REG_BIT_COUNT))
        begin
            bit_count_next = pwdata[BC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= BIT_COUNT_RESET;
        end
        else
        begin
            bit_count_reg <= bit_count_next;
        end
    end

    assign prdata    = (reg_idx == REG_BIT_COUNT) ? DATA_W'(bit_count_reg) : '0;
    assign bit_count = bit_count_reg;

endmodule

/* sv/pcaw_ctrl.sv */
// Sequencer for the popcount witness: load, adder walk per level, flush, byte output.
// Depends on pcaw_pkg; drives pcaw_dp through pcaw_cmd_t.
module pcaw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  last_byte,
    input  logic                  out_stall,
    input  pcaw_pkg::pcaw_stat_t  stat,
    output logic                  in_stall,
    output pcaw_pkg::pcaw_cmd_t   cmd
);
    import pcaw_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAPTURE,
        ST_INBITS,
        ST_WALK_INIT,
        ST_WALK,
        ST_NEXT_LEVEL,
        ST_CARRY,
        ST_FLUSH,
        ST_OUT_READ,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_accept;

    // final bytes start a message only from idle
    assign in_stall  = (state_reg == ST_CAPTURE) || ((state_reg != ST_IDLE) && last_byte);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load   = in_accept;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && last_byte)
                begin
                    state_next = ST_CAPTURE;
                end
            end
            ST_CAPTURE:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_INBITS;
            end
            ST_INBITS:
            begin
                cmd.emit_in = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = stat.len_one ? ST_FLUSH : ST_WALK_INIT;
                end
            end
            ST_WALK_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = ST_NEXT_LEVEL;
                end
            end
            ST_NEXT_LEVEL:
            begin
                cmd.next_level = 1'b1;
                state_next     = ST_CARRY;
            end
            ST_CARRY:
            begin
                cmd.emit_car = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = stat.len_one ? ST_FLUSH : ST_WALK_INIT;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush     = 1'b1;
                cmd.out_start = 1'b1;
                state_next    = ST_OUT_READ;
            end
            ST_OUT_READ:
            begin
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (!out_stall)
                begin
                    cmd.out_adv = 1'b1;
                    state_next  = stat.out_last ? ST_IDLE : ST_OUT_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/pcaw_dp.sv */
// Datapath: input byte slots, level shifters, one full adder, bit packer, witness memory,
// output register. Depends on pcaw_pkg; controlled by pcaw_ctrl.
module pcaw_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pcaw_pkg::pcaw_cmd_t            cmd,
    output pcaw_pkg::pcaw_stat_t           stat,
    input  logic [pcaw_pkg::BYTE_W-1:0]    data_byte,
    input  logic [pcaw_pkg::BC_W-1:0]      bit_count,
    output logic                           out_valid,
    output logic [pcaw_pkg::BYTE_W-1:0]    witness_byte,
    output logic [pcaw_pkg::INDEX_W-1:0]   byte_index,
    output logic [pcaw_pkg::WEIGHT_W-1:0]  weight,
    output logic                           last_result
);
    import pcaw_pkg::*;

    logic [IN_BYTES-1:0][BYTE_W-1:0] in_bytes_reg, in_bytes_next;
    logic [LP_W-1:0]                 lp_reg, lp_next;
    logic [MAX_BITS-1:0]             lv_reg, lv_next;
    logic [MAX_BITS-1:0]             car_reg, car_next;
    logic                            sum_reg, sum_next;
    logic [LV_IDX_W-1:0]             widx_reg, widx_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [CNT_W-1:0]                len_reg, len_next;
    logic [WEIGHT_W-1:0]             weight_reg, weight_next;
    logic [POS_W-1:0]                pos_reg, pos_next;
    logic [BYTE_W-1:0]               acc_reg, acc_next;
    logic [NB_W-1:0]                 nbytes_reg, nbytes_next;
    logic [MEM_AW-1:0]               out_idx_reg, out_idx_next;
    logic [BYTE_W-1:0]               rdata_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]               witness_byte_reg, witness_byte_next;
    logic [INDEX_W-1:0]              byte_index_reg, byte_index_next;
    logic [WEIGHT_W-1:0]             weight_out_reg, weight_out_next;
    logic                            last_result_reg, last_result_next;

    logic [BYTE_W-1:0] witness_mem [STORE_BYTES];

    logic [CNT_W-1:0]    m_eff;
    logic [MAX_BITS-1:0] masked;
    logic                fa_sum;
    logic                fa_car;
    logic                emit;
    logic                emit_bit;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [BYTE_W-1:0]   mem_wdata;
    logic                out_last;

    always_comb
    begin
        if (bit_count == '0)
        begin
            m_eff = CNT_W'(1);
        end
        else if (int'(bit_count) > MAX_BITS)
        begin
            m_eff = CNT_W'(MAX_BITS);
        end
        else
        begin
            m_eff = CNT_W'(bit_count);
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_BITS; k++)
        begin
            masked[k] = in_bytes_reg[k / BYTE_W][k % BYTE_W] && (k < int'(m_eff));
        end
    end

    assign fa_sum   = sum_reg ^ lv_reg[0] ^ lv_reg[1];
    assign fa_car   = (sum_reg & lv_reg[0]) | (sum_reg & lv_reg[1]) | (lv_reg[0] & lv_reg[1]);
    assign emit     = cmd.emit_in || cmd.walk || cmd.emit_car;
    assign emit_bit = cmd.walk ? fa_sum : car_reg[0];
    assign out_last = (NB_W'(out_idx_reg) + NB_W'(1)) == nbytes_reg;

    assign stat.cnt_last = (cnt_reg == CNT_W'(1));
    assign stat.len_one  = (len_reg == CNT_W'(1));
    assign stat.out_last = out_last;

    always_comb
    begin
        in_bytes_next     = in_bytes_reg;
        lp_next           = lp_reg;
        lv_next           = lv_reg;
        car_next          = car_reg;
        sum_next          = sum_reg;
        widx_next         = widx_reg;
        cnt_next          = cnt_reg;
        len_next          = len_reg;
        weight_next       = weight_reg;
        pos_next          = pos_reg;
        acc_next          = acc_reg;
        nbytes_next       = nbytes_reg;
        out_idx_next      = out_idx_reg;
        out_valid_next    = out_valid_reg;
        witness_byte_next = witness_byte_reg;
        byte_index_next   = byte_index_reg;
        weight_out_next   = weight_out_reg;
        last_result_next  = last_result_reg;
        mem_we            = 1'b0;
        mem_waddr         = MEM_AW'(pos_reg >> 3);
        mem_wdata         = acc_reg;

        if (cmd.load && (lp_reg < LP_W'(IN_BYTES)))
        begin
            in_bytes_next[lp_reg[IB_IDX_W-1:0]] = data_byte;
            lp_next = lp_reg + LP_W'(1);
        end

        if (cmd.capture)
        begin
            in_bytes_next = '0;
            lp_next       = '0;
            lv_next       = masked;
            car_next      = masked;
            cnt_next      = m_eff;
            len_next      = m_eff;
            weight_next   = '0;
            pos_next      = '0;
            acc_next      = '0;
        end

        if (cmd.emit_in)
        begin
            weight_next = weight_reg + WEIGHT_W'(car_reg[0]);
        end

        if (cmd.emit_in || cmd.emit_car)
        begin
            car_next = car_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
        end

        if (cmd.walk_init)
        begin
            sum_next  = lv_reg[0];
            lv_next   = lv_reg >> 1;
            car_next  = '0;
            widx_next = '0;
            cnt_next  = len_reg >> 1;
        end

        if (cmd.walk)
        begin
            sum_next           = fa_sum;
            lv_next            = lv_reg >> 2;
            car_next[widx_reg] = fa_car;
            widx_next          = widx_reg + LV_IDX_W'(1);
            cnt_next           = cnt_reg - CNT_W'(1);
        end

        if (cmd.next_level)
        begin
            lv_next  = car_reg;
            len_next = len_reg >> 1;
            cnt_next = len_reg >> 1;
        end

        // pack bits into bytes; write a byte once its top bit lands
        if (emit)
        begin
            if (pos_reg[2:0] == 3'd7)
            begin
                mem_we    = 1'b1;
                mem_wdata = {emit_bit, acc_reg[BYTE_W-2:0]};
                acc_next  = '0;
            end
            else
            begin
                acc_next[pos_reg[2:0]] = emit_bit;
            end
            pos_next = pos_reg + POS_W'(1);
        end

        if (cmd.flush)
        begin
            nbytes_next = NB_W'(pos_reg >> 3) + NB_W'(pos_reg[2:0] != 3'd0);
            if (pos_reg[2:0] != 3'd0)
            begin
                mem_we = 1'b1;
            end
        end

        if (cmd.out_start)
        begin
            out_idx_next = '0;
        end

        if (cmd.out_load)
        begin
            out_valid_next    = 1'b1;
            witness_byte_next = rdata_reg;
            byte_index_next   = INDEX_W'(out_idx_reg);
            weight_out_next   = out_last ? weight_reg : '0;
            last_result_next  = out_last;
        end

        if (cmd.out_adv)
        begin
            out_valid_next = 1'b0;
            out_idx_next   = out_idx_reg + MEM_AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bytes_reg  <= '0;
            lp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_bytes_reg  <= in_bytes_next;
            lp_reg        <= lp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lv_reg           <= lv_next;
        car_reg          <= car_next;
        sum_reg          <= sum_next;
        widx_reg         <= widx_next;
        cnt_reg          <= cnt_next;
        len_reg          <= len_next;
        weight_reg       <= weight_next;
        pos_reg          <= pos_next;
        acc_reg          <= acc_next;
        nbytes_reg       <= nbytes_next;
        out_idx_reg      <= out_idx_next;
        witness_byte_reg <= witness_byte_next;
        byte_index_reg   <= byte_index_next;
        weight_out_reg   <= weight_out_next;
        last_result_reg  <= last_result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            witness_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= witness_mem[out_idx_reg];
    end

    assign out_valid    = out_valid_reg;
    assign witness_byte = witness_byte_reg;
    assign byte_index   = byte_index_reg;
    assign weight       = weight_out_reg;
    assign last_result  = last_result_reg;

endmodule

/* sv/popcount_adder_witness.sv */
// Popcount full-adder-chain witness. Input bytes load one per cycle, and bytes of the next
// message keep loading while the current one is worked on; a final byte waits for idle, and
// every byte waits out the single capture cycle that follows a final byte. After capture,
// one full adder runs per cycle: the m input bits stream out first, then each adder level
// walks its bit pairs through the adder and copies out its carries, and a flush writes any
// partial last byte. The witness then leaves the witness memory through read, load and wait
// states per byte, 48 bytes for m = 128, and an output stall holds each byte in the wait state.
// The total weight rides on the final byte.
`include "popcount_adder_witness_defines.svh"

module popcount_adder_witness (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcaw_pkg::ADDR_W-1:0]    paddr,
    input  logic [pcaw_pkg::DATA_W-1:0]    pwdata,
    output logic [pcaw_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pcaw_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           last_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pcaw_pkg::BYTE_W-1:0]    witness_byte,
    output logic [pcaw_pkg::INDEX_W-1:0]   byte_index,
    output logic [pcaw_pkg::WEIGHT_W-1:0]  weight,
    output logic                           last_result
);
    import pcaw_pkg::*;

    logic [BC_W-1:0] bit_count;
    pcaw_cmd_t       cmd;
    pcaw_stat_t      stat;

    pcaw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .bit_count (bit_count)
    );

    pcaw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_byte (last_byte),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    pcaw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .data_byte    (data_byte),
        .bit_count    (bit_count),
        .out_valid    (out_valid),
        .witness_byte (witness_byte),
        .byte_index   (byte_index),
        .weight       (weight),
        .last_result  (last_result)
    );

    `PCAW_ASSERT_IMP(a_no_start_while_busy, out_valid, !(in_valid && !in_stall && last_byte), "final byte taken while results pending")
    `PCAW_ASSERT_IMP(a_weight_on_last_only, out_valid && !last_result, weight == '0, "weight set on a non-final item")
    `PCAW_ASSERT_NXT(a_idle_after_last, out_valid && !out_stall && last_result, !in_stall, "input not open after final item")

endmodule

/* tb/tb_popcount_adder_witness.sv */
// Self-checking testbench for popcount_adder_witness: directed table then random messages,
// each witness byte compared against an in-bench full-adder chain predictor or a typed table row.
// Depends on pcaw_pkg and the popcount_adder_witness RTL.
module tb_popcount_adder_witness;
    timeunit 1ns;
    timeprecision 1ps;

    import pcaw_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int ITEM_TARGET = 370;
    localparam int IDLE_PCT    = 32;

    typedef struct packed {
        logic [BYTE_W-1:0]   wbyte;
        logic [INDEX_W-1:0]  idx;
        logic [WEIGHT_W-1:0] wt;
        logic                fin;
    } witness_out_t;

    typedef struct packed {
        logic              set_cfg;
        logic [BC_W-1:0]   cfg;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              typed;
        logic [31:0]       t_count;
        logic [BYTE_W-1:0] t_byte;
        logic [WEIGHT_W-1:0] t_weight;
    } drow_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    data_byte;
    logic                 last_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_W-1:0]    witness_byte;
    logic [INDEX_W-1:0]   byte_index;
    logic [WEIGHT_W-1:0]  weight;
    logic                 last_result;

    logic [BYTE_W-1:0] witness_mem [STORE_BYTES];
    int unsigned       load_slot;
    logic [BC_W-1:0]   bit_count_reg;
    witness_out_t      witness_due [$];
    int unsigned       mismatches;
    int unsigned       sent_items;
    int unsigned       cycles;
    bit                steady;
    drow_t             plan [0:14];

    popcount_adder_witness u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .witness_byte (witness_byte),
        .byte_index   (byte_index),
        .weight       (weight),
        .last_result  (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 30)
            $display("ERROR at cycle %0d: %s", cycles, msg);
    endtask

    function automatic logic wit_bit(input int unsigned pos);
        if ((pos >> 3) >= STORE_BYTES)
            return 1'b0;
        return witness_mem[pos >> 3][pos & 7];
    endfunction

    function automatic void set_wit_bit(input int unsigned pos, input logic v);
        if ((pos >> 3) < STORE_BYTES)
            witness_mem[pos >> 3][pos & 7] = v;
    endfunction

    function automatic void clear_witness();
        for (int k = 0; k < STORE_BYTES; k++)
            witness_mem[k] = '0;
        load_slot = 0;
    endfunction

    // Absorb one accepted item; on a final byte build the witness and queue its bytes when queue_it is set.
    task automatic absorb_byte(input logic [BYTE_W-1:0] d, input logic fin, input bit queue_it);
        int unsigned m, len, base, half, s0, c0, nbits, nbytes, tally, i;
        logic x1, x2, x3;
        witness_out_t w;
        if (load_slot < IN_BYTES)
        begin
            witness_mem[load_slot] = d;
            load_slot++;
        end
        if (!fin)
            return;
        m = bit_count_reg;
        if (m == 0)
            m = 1;
        if (m > MAX_BITS)
            m = MAX_BITS;
        for (int unsigned p = m; p < STORE_BYTES * 8; p++)
            set_wit_bit(p, 1'b0);
        tally = 0;
        for (int unsigned p = 0; p < m; p++)
            tally += wit_bit(p);
        len = m;
        base = 0;
        while (len > 1)
        begin
            half = len / 2;
            s0 = base + len;
            c0 = base + len + half;
            for (i = 0; i < (len - 1) / 2; i++)
            begin
                x1 = (i == 0) ? wit_bit(base) : wit_bit(s0 + i - 1);
                x2 = wit_bit(base + 2 * i + 1);
                x3 = wit_bit(base + 2 * i + 2);
                set_wit_bit(s0 + i, x1 ^ x2 ^ x3);
                set_wit_bit(c0 + i, (x1 & x2) | (x1 & x3) | (x2 & x3));
            end
            if (len % 2 == 0)
            begin
                i = half - 1;
                x1 = (i == 0) ? wit_bit(base) : wit_bit(s0 + i - 1);
                x2 = wit_bit(base + len - 1);
                set_wit_bit(s0 + i, x1 ^ x2);
                set_wit_bit(c0 + i, x1 & x2);
            end
            base += len + half;
            len = half;
        end
        nbits = base + 1;
        nbytes = (nbits + 7) / 8;
        if (nbytes > STORE_BYTES)
            nbytes = STORE_BYTES;
        if (queue_it)
        begin
            for (int unsigned k = 0; k < nbytes; k++)
            begin
                w.wbyte = witness_mem[k];
                w.idx   = INDEX_W'(k);
                w.fin   = (k + 1 == nbytes);
                w.wt    = w.fin ? WEIGHT_W'(tally) : '0;
                witness_due.push_back(w);
            end
        end
        clear_witness();
    endtask

    task automatic queue_typed(input int unsigned n, input logic [BYTE_W-1:0] lastval,
                               input logic [WEIGHT_W-1:0] wt);
        witness_out_t w;
        for (int unsigned k = 0; k < n; k++)
        begin
            w.idx   = INDEX_W'(k);
            w.fin   = (k + 1 == n);
            w.wbyte = w.fin ? lastval : '0;
            w.wt    = w.fin ? wt : '0;
            witness_due.push_back(w);
        end
    endtask

    task automatic check_witness_byte();
        witness_out_t want;
        if (witness_due.size() == 0)
        begin
            note_error($sformatf("unexpected witness byte, index %0d", byte_index));
            return;
        end
        want = witness_due.pop_front();
        if (witness_byte !== want.wbyte)
            note_error($sformatf("witness_byte idx %0d: got %02h want %02h",
                                 want.idx, witness_byte, want.wbyte));
        if (byte_index !== want.idx)
            note_error($sformatf("byte_index: got %0d want %0d", byte_index, want.idx));
        if (weight !== want.wt)
            note_error($sformatf("weight idx %0d: got %0d want %0d", want.idx, weight, want.wt));
        if (last_result !== want.fin)
            note_error($sformatf("last_result idx %0d: got %0b want %0b",
                                 want.idx, last_result, want.fin));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_witness_byte();
            out_stall <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic write_bit_count(input logic [BC_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * REG_BIT_COUNT);
        pwdata  <= {(DATA_W - BC_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bit_count_reg = value;
    endtask

    // Drop valid and wait until every queued witness byte has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (witness_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic fin, input bit typed,
                             input int unsigned t_count, input logic [BYTE_W-1:0] t_byte,
                             input logic [WEIGHT_W-1:0] t_weight);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= fin;
        do
            @(posedge clk);
        while (in_stall);
        absorb_byte(d, fin, !typed);
        if (typed)
            queue_typed(t_count, t_byte, t_weight);
        sent_items++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_data();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return BYTE_W'($urandom);
    endfunction

    function automatic logic [BC_W-1:0] pick_bit_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
        begin
            case ($urandom_range(4))
                0: return BC_W'(0);
                1: return BC_W'(1);
                2: return BC_W'(2);
                3: return BC_W'(MAX_BITS);
                default: return BC_W'(255);
            endcase
        end
        if (r < 30)
            return BC_W'($urandom_range(MAX_BITS + 1, 254));
        return BC_W'($urandom_range(1, MAX_BITS));
    endfunction

    initial
    begin
        int unsigned m, nb, len, nmsg;
        logic [BC_W-1:0] cfg;

        plan = '{
            '{1'b0, 8'd0,   8'h00, 1'b1, 1'b1, 32'd48, 8'h00, 8'd0},
            '{1'b0, 8'd0,   8'hFF, 1'b0, 1'b0, 32'd0,  8'h00, 8'd0},
            '{1'b0, 8'd0,   8'hA5, 1'b0, 1'b0, 32'd0,  8'h00, 8'd0},
            '{1'b0, 8'd0,   8'hFF, 1'b1, 1'b0, 32'd0,  8'h00, 8'd0},
            '{1'b1, 8'd1,   8'hFF, 1'b1, 1'b1, 32'd1,  8'h01, 8'd1},
            '{1'b0, 8'd0,   8'hFE, 1'b1, 1'b1, 32'd1,  8'h00, 8'd0},
            '{1'b1, 8'd0,   8'hFF, 1'b1, 1'b1, 32'd1,  8'h01, 8'd1},
            '{1'b1, 8'd2,   8'h03, 1'b1, 1'b1, 32'd1,  8'h0B, 8'd2},
            '{1'b1, 8'd255, 8'hFF, 1'b0, 1'b0, 32'd0,  8'h00, 8'd0},
            '{1'b0, 8'd0,   8'hFF, 1'b1, 1'b0, 32'd0,  8'h00, 8'd0},
            '{1'b1, 8'd9,   8'hFF, 1'b0, 1'b0, 32'd0,  8'h00, 8'd0},
            '{1'b0, 8'd0,   8'h03, 1'b1, 1'b0, 32'd0,  8'h00, 8'd0},
            '{1'b1, 8'd3,   8'h07, 1'b1, 1'b0, 32'd0,  8'h00, 8'd0},
            '{1'b1, 8'd200, 8'h00, 1'b0, 1'b0, 32'd0,  8'h00, 8'd0},
            '{1'b0, 8'd0,   8'h80, 1'b1, 1'b0, 32'd0,  8'h00, 8'd0}
        };

        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        data_byte     <= '0;
        last_byte     <= 1'b0;
        mismatches    = 0;
        sent_items    = 0;
        steady        = 1'b0;
        bit_count_reg = BIT_COUNT_RESET;
        clear_witness();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            if (plan[r].set_cfg)
            begin
                drain();
                write_bit_count(plan[r].cfg);
            end
            send_byte(plan[r].data, plan[r].last, plan[r].typed, plan[r].t_count,
                      plan[r].t_byte, plan[r].t_weight);
        end

        cfg = BC_W'(MAX_BITS);
        while (sent_items < ITEM_TARGET)
        begin
            drain();
            write_bit_count(cfg);
            m = (cfg == 0) ? 1 : ((cfg > MAX_BITS) ? MAX_BITS : cfg);
            nb = (m + 7) / 8;
            nmsg = $urandom_range(2, 5);
            for (int unsigned g = 0; g < nmsg && sent_items < ITEM_TARGET; g++)
            begin
                steady = (sent_items >= 180 && sent_items < 260);
                case ($urandom_range(99) / 10)
                    7, 8:    len = $urandom_range(1, nb);
                    9:       len = $urandom_range(nb + 1, IN_BYTES + 4);
                    default: len = nb;
                endcase
                for (int unsigned b = 0; b < len; b++)
                    send_byte(pick_data(), b + 1 == len, 1'b0, 0, '0, '0);
            end
            cfg = pick_bit_count();
        end
        steady = 1'b0;

        drain();
        repeat (200) @(posedge clk);
        if (witness_due.size() != 0)
            note_error($sformatf("%0d witness bytes never arrived", witness_due.size()));
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
